/* hw/rtl/bps_pkg.sv */
// Shared constants and types for the battery power supervisor.
package bps_pkg;

  // Field widths
  localparam int unsigned SampleW   = 12;
  localparam int unsigned MvW       = 14;
  localparam int unsigned TicksW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 14;

  // Sample to millivolt scaling: mv = sample * MvScale >> MvShift
  localparam int unsigned MvScale   = 1125;
  localparam int unsigned MvScaleW  = 11;
  localparam int unsigned MvShift   = 9;
  localparam int unsigned MvProdW   = SampleW + MvScaleW;

  // Key debounce
  localparam int unsigned DebounceMax = 2;
  localparam int unsigned DebounceW   = $clog2(DebounceMax + 1);

  // Low-voltage run counter saturates at LowRunSat
  localparam int unsigned LowRunSat = 256;
  localparam int unsigned LowRunW   = $clog2(LowRunSat + 1);

  // IIR filter
  localparam int unsigned FilterShift = 8;
  localparam int unsigned FilterAccW  = MvW + FilterShift;

  // Register reset values
  localparam logic [MvW-1:0]    LowMvReset    = MvW'(5500);
  localparam logic [TicksW-1:0] LowTicksReset = TicksW'(100);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegLowVoltageMv    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegLowVoltageTicks = CfgIdxW'(1);

  typedef struct packed {
    logic [MvW-1:0]    low_mv;
    logic [TicksW-1:0] low_ticks;
  } bps_cfg_t;

  typedef struct packed {
    logic           hold_power;
    logic [MvW-1:0] battery_mv;
    logic [MvW-1:0] filtered_mv;
    logic           key_debounced;
  } bps_result_t;

endpackage

/* hw/rtl/bps_step.sv */
// Supervisor state and the per-tick update: scaling, debounce, low-voltage run, filter.
module bps_step
  import bps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [SampleW-1:0] adc_sample_i,
  input  logic               key_level_i,
  input  bps_cfg_t           cfg_i,
  output bps_result_t        result_o
);

  logic [DebounceW-1:0]  deb_cnt_q, deb_cnt_d;
  logic                  key_state_q, key_state_d;
  logic                  released_q, released_d;
  logic [LowRunW-1:0]    low_run_q, low_run_d;
  logic                  hold_q, hold_d;
  logic [FilterAccW-1:0] acc_q, acc_d;
  logic [MvW-1:0]        filt_q, filt_d;

  logic [MvProdW-1:0]    prod;
  logic [MvW-1:0]        mv;
  logic [MvW-1:0]        filt_base;
  logic [FilterAccW-1:0] acc_base;

  // Scale sample to millivolts
  assign prod = MvProdW'(adc_sample_i) * MvProdW'(MvScale);
  assign mv   = MvW'(prod >> MvShift);

  // Debounce counter and release mark
  always_comb begin
    deb_cnt_d   = deb_cnt_q;
    key_state_d = key_state_q;
    if (key_level_i) begin
      if (deb_cnt_q < DebounceW'(DebounceMax)) deb_cnt_d = deb_cnt_q + 1'b1;
      else key_state_d = 1'b1;
    end else begin
      if (deb_cnt_q != '0) deb_cnt_d = deb_cnt_q - 1'b1;
      else key_state_d = 1'b0;
    end
    released_d = released_q | ~key_state_d;
  end

  // Low-voltage run, saturating
  always_comb begin
    if (mv < cfg_i.low_mv) begin
      if (low_run_q < LowRunW'(LowRunSat)) low_run_d = low_run_q + 1'b1;
      else low_run_d = low_run_q;
    end else begin
      low_run_d = '0;
    end
  end

  // Switch-off latch
  always_comb begin
    hold_d = hold_q;
    if (released_d && key_state_d) hold_d = 1'b0;
    if (low_run_d > LowRunW'(cfg_i.low_ticks)) hold_d = 1'b0;
  end

  // IIR filter, loaded directly while its value is zero
  always_comb begin
    if (filt_q == '0) begin
      filt_base = mv;
      acc_base  = FilterAccW'(mv) << FilterShift;
    end else begin
      filt_base = filt_q;
      acc_base  = acc_q;
    end
    acc_d  = acc_base - FilterAccW'(filt_base) + FilterAccW'(mv);
    filt_d = MvW'(acc_d >> FilterShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_cnt_q   <= DebounceW'(DebounceMax);
      key_state_q <= 1'b1;
      released_q  <= 1'b0;
      low_run_q   <= '0;
      hold_q      <= 1'b1;
      acc_q       <= '0;
      filt_q      <= '0;
    end else if (fire_i) begin
      deb_cnt_q   <= deb_cnt_d;
      key_state_q <= key_state_d;
      released_q  <= released_d;
      low_run_q   <= low_run_d;
      hold_q      <= hold_d;
      acc_q       <= acc_d;
      filt_q      <= filt_d;
    end
  end

  assign result_o.hold_power    = hold_d;
  assign result_o.battery_mv    = mv;
  assign result_o.filtered_mv   = filt_d;
  assign result_o.key_debounced = key_state_d;

endmodule

/* hw/rtl/battery_power_supervisor_core.sv */
// Top level of the battery power supervisor: config registers, step logic, output buffer.
//
// Takes one word per clock while in_stall_o is low (adc_sample_i, key_level_i) and
// returns one result word per input word from an output register. A second skid
// register behind the output register absorbs one word when the consumer stalls, so
// in_stall_o is registered; with no output stall, throughput is one word per cycle.
// All per-tick work (x1125>>9 scaling, debounce, low-voltage run count, IIR filter
// update) is done in the accepting cycle. Configuration writes are always ready and
// must only be issued while the block is idle; unknown register indexes are ignored.
module battery_power_supervisor_core
  import bps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  adc_sample_i,
  input  logic                key_level_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                hold_power_o,
  output logic [MvW-1:0]      battery_mv_o,
  output logic [MvW-1:0]      filtered_mv_o,
  output logic                key_debounced_o,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  bps_cfg_t    cfg_q;
  bps_result_t step_res;
  bps_result_t out_q, out_d;
  bps_result_t skid_q, skid_d;
  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  logic        in_fire, out_fire;

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_mv    <= LowMvReset;
      cfg_q.low_ticks <= LowTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegLowVoltageMv:    cfg_q.low_mv    <= MvW'(cfg_data_i);
        RegLowVoltageTicks: cfg_q.low_ticks <= cfg_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  bps_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .adc_sample_i (adc_sample_i),
    .key_level_i  (key_level_i),
    .cfg_i        (cfg_q),
    .result_o     (step_res)
  );

  // Output register plus skid word
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = step_res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = step_res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign hold_power_o    = out_q.hold_power;
  assign battery_mv_o    = out_q.battery_mv;
  assign filtered_mv_o   = out_q.filtered_mv;
  assign key_debounced_o = out_q.key_debounced;

endmodule
